>>> hw/rtl/rrq_pkg.sv
// Round-robin ready queue: shared constants, codes and index helpers.
// Used by the top level; no dependencies.
`default_nettype none

package rrq_pkg;

  // Sizes of the slot store and the ids it holds
  localparam int QUEUE_DEPTH = 256;
  localparam int ID_BITS     = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Fixed field widths of the beats
  localparam int QCNT_W  = 9;
  localparam int IN_W    = 24;
  localparam int OUT_W   = 48;
  localparam int USER_W  = 2;
  localparam int CFG_I_W = 1;
  localparam int CFG_D_W = 16;

  // Operation codes (in_tuser)
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_YIELD = 2'd1;
  localparam logic [1:0] OP_SET   = 2'd2;

  // Status of the current process on a yield
  localparam logic [1:0] CS_RUNNING = 2'd0;
  localparam logic [1:0] CS_EXITED  = 2'd1;

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NOSW = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_I_W-1:0] REG_IDLE_ID    = 1'b0;
  localparam logic [CFG_I_W-1:0] REG_IDLE_AVAIL = 1'b1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_POP   = 6'b000010,
    S_SCAN  = 6'b000100,
    S_SHIFT = 6'b001000,
    S_PICK  = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  // Slot index a + b, wrapped round the ring
  function automatic logic [IDX_W-1:0] idx_add(input logic [IDX_W-1:0] a,
                                               input logic [IDX_W-1:0] b);
    logic [IDX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (IDX_W+1)'(QUEUE_DEPTH)) begin
      s = s - (IDX_W+1)'(QUEUE_DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] a);
    return idx_add(a, IDX_W'(1));
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] a);
    logic [IDX_W-1:0] r;
    if (a == '0) begin
      r = IDX_W'(QUEUE_DEPTH - 1);
    end else begin
      r = a - IDX_W'(1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/round_robin_ready_queue_top.sv
// Round-robin ready queue scheduler, top level.
// Depends on rrq_pkg and the slot RAM rrq_ram.
`default_nettype none

// One result beat per input beat. Add and set current go from the idle state
// through the emit state to the output register; a yield outside interrupt context
// passes through pop and pick first, as the popped id comes back from the slot RAM
// in the cycle after its read. A yield whose current process has exited walks the
// ids left in the queue after the pop through the RAM's single read port, one
// entry per cycle. Input is taken while the previous result still waits in the
// output register.
// The slot RAM needs no clearing pass: only slots between head and tail are
// ever read. Configuration writes are always taken.
module round_robin_ready_queue_top
  import rrq_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  // Input channel
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  // [15:0] process_id, [16] process_id_valid, [18:17] current_status,
  // [19] in_interrupt, [23:20] zero
  input  wire logic [IN_W-1:0]    in_tdata,
  // [1:0] operation
  input  wire logic [USER_W-1:0]  in_tuser,
  // Result channel
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  // [1:0] status, [2] switched, [18:3] previous_id, [19] previous_valid,
  // [35:20] current_id, [36] current_valid, [45:37] queue_count, [47:46] zero
  output logic [OUT_W-1:0]        out_tdata,
  // Configuration channel
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CFG_I_W-1:0] cfg_index,
  input  wire logic [CFG_D_W-1:0] cfg_data
);

  // Control state
  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   head_r, head_nxt;
  logic [IDX_W-1:0]   tail_r, tail_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [ID_BITS-1:0] run_id_r, run_id_nxt;
  logic               run_valid_r, run_valid_nxt;
  logic [ID_BITS-1:0] idle_id_r;
  logic               idle_avail_r;
  logic               out_valid_r, out_valid_nxt;

  // Per-item working registers
  logic [ID_BITS-1:0] prev_id_r, prev_id_nxt;
  logic               prev_valid_r, prev_valid_nxt;
  logic [1:0]         cstat_r, cstat_nxt;
  logic               have_r, have_nxt;
  logic [ID_BITS-1:0] next_r, next_nxt;
  logic [IDX_W-1:0]   k_r, k_nxt;
  logic [1:0]         res_status_r, res_status_nxt;
  logic               res_switched_r, res_switched_nxt;
  logic [OUT_W-1:0]   out_data_r, out_data_nxt;

  // Slot RAM access
  logic               ram_wr_en;
  logic [IDX_W-1:0]   ram_wr_addr;
  logic [ID_BITS-1:0] ram_wr_data;
  logic               ram_rd_en;
  logic [IDX_W-1:0]   ram_rd_addr;
  logic [ID_BITS-1:0] ram_rd_data;

  logic               in_fire;
  logic               cfg_fire;
  logic [CNT_W-1:0]   k_plus1;
  logic               more_left;
  logic [ID_BITS-1:0] pick_id;
  logic               pick_have;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign cfg_fire   = cfg_valid && cfg_ready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Walk position helpers
  assign k_plus1   = CNT_W'(k_r) + CNT_W'(1);
  assign more_left = (k_plus1 < count_r);

  // Idle fallback when nothing was popped
  assign pick_have = have_r || idle_avail_r;
  assign pick_id   = have_r ? next_r : idle_id_r;

  rrq_ram #(
    .WIDTH (ID_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_slots (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Sequencer
  always_comb begin
    state_nxt        = state_r;
    head_nxt         = head_r;
    tail_nxt         = tail_r;
    count_nxt        = count_r;
    run_id_nxt       = run_id_r;
    run_valid_nxt    = run_valid_r;
    out_valid_nxt    = out_valid_r;
    prev_id_nxt      = prev_id_r;
    prev_valid_nxt   = prev_valid_r;
    cstat_nxt        = cstat_r;
    have_nxt         = have_r;
    next_nxt         = next_r;
    k_nxt            = k_r;
    res_status_nxt   = res_status_r;
    res_switched_nxt = res_switched_r;
    out_data_nxt     = out_data_r;
    ram_wr_en        = 1'b0;
    ram_wr_addr      = tail_r;
    ram_wr_data      = run_id_r;
    ram_rd_en        = 1'b0;
    ram_rd_addr      = head_r;

    // Result taken downstream
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          prev_id_nxt      = run_valid_r ? run_id_r : '0;
          prev_valid_nxt   = run_valid_r;
          cstat_nxt        = in_tdata[18:17];
          res_status_nxt   = ST_OK;
          res_switched_nxt = 1'b0;
          state_nxt        = S_EMIT;
          unique case (in_tuser)
            OP_ADD: begin
              if (count_r == CNT_W'(QUEUE_DEPTH)) begin
                res_status_nxt = ST_FULL;
              end else begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = tail_r;
                ram_wr_data = in_tdata[ID_BITS-1:0];
                tail_nxt    = idx_inc(tail_r);
                count_nxt   = count_r + CNT_W'(1);
              end
            end
            OP_SET: begin
              run_valid_nxt = in_tdata[16];
              run_id_nxt    = in_tdata[16] ? in_tdata[ID_BITS-1:0] : '0;
            end
            OP_YIELD: begin
              if (in_tdata[19]) begin
                res_status_nxt = ST_NOSW;
              end else begin
                // Pop the head
                have_nxt = (count_r != '0);
                if (count_r != '0) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = head_r;
                  head_nxt    = idx_inc(head_r);
                  count_nxt   = count_r - CNT_W'(1);
                end
                state_nxt = S_POP;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_POP: begin
        next_nxt  = ram_rd_data;
        state_nxt = S_PICK;
        // Requeue a running process, or start the search for an exited one
        if (run_valid_r && cstat_r == CS_RUNNING) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = tail_r;
          ram_wr_data = run_id_r;
          tail_nxt    = idx_inc(tail_r);
          count_nxt   = count_r + CNT_W'(1);
        end else if (run_valid_r && cstat_r == CS_EXITED && count_r != '0) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = head_r;
          k_nxt       = '0;
          state_nxt   = S_SCAN;
        end
      end

      S_SCAN: begin
        // Data in hand is slot k; next slot read goes out alongside
        if (ram_rd_data == run_id_r) begin
          if (more_left) begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = idx_add(head_r, k_plus1[IDX_W-1:0]);
            k_nxt       = k_plus1[IDX_W-1:0];
            state_nxt   = S_SHIFT;
          end else begin
            tail_nxt  = idx_dec(tail_r);
            count_nxt = count_r - CNT_W'(1);
            state_nxt = S_PICK;
          end
        end else if (more_left) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = idx_add(head_r, k_plus1[IDX_W-1:0]);
          k_nxt       = k_plus1[IDX_W-1:0];
        end else begin
          state_nxt = S_PICK;
        end
      end

      S_SHIFT: begin
        // Close the gap: slot k moves down to slot k-1
        ram_wr_en   = 1'b1;
        ram_wr_addr = idx_add(head_r, k_r - IDX_W'(1));
        ram_wr_data = ram_rd_data;
        if (more_left) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = idx_add(head_r, k_plus1[IDX_W-1:0]);
          k_nxt       = k_plus1[IDX_W-1:0];
        end else begin
          tail_nxt  = idx_dec(tail_r);
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_PICK;
        end
      end

      S_PICK: begin
        if (pick_have && (!run_valid_r || pick_id != run_id_r)) begin
          run_id_nxt       = pick_id;
          run_valid_nxt    = 1'b1;
          res_switched_nxt = 1'b1;
          res_status_nxt   = ST_OK;
        end else begin
          res_status_nxt   = ST_NOSW;
        end
        state_nxt = S_EMIT;
      end

      S_EMIT: begin
        // Load the output register once it is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {2'b00,
                           QCNT_W'(count_r),
                           run_valid_r,
                           run_valid_r ? run_id_r : {ID_BITS{1'b0}},
                           prev_valid_r,
                           prev_id_r,
                           res_switched_r,
                           res_status_r};
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      run_id_r    <= '0;
      run_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      run_id_r    <= run_id_nxt;
      run_valid_r <= run_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_id_r    <= '0;
      idle_avail_r <= 1'b1;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        REG_IDLE_ID:    idle_id_r    <= cfg_data[ID_BITS-1:0];
        REG_IDLE_AVAIL: idle_avail_r <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Working and payload registers
  always_ff @(posedge clk) begin
    prev_id_r      <= prev_id_nxt;
    prev_valid_r   <= prev_valid_nxt;
    cstat_r        <= cstat_nxt;
    have_r         <= have_nxt;
    next_r         <= next_nxt;
    k_r            <= k_nxt;
    res_status_r   <= res_status_nxt;
    res_switched_r <= res_switched_nxt;
    out_data_r     <= out_data_nxt;
  end

endmodule

`default_nettype wire

>>> hw/rtl/rrq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read of the address being written returns the old contents. No dependencies.
`default_nettype none

module rrq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]              rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> verif/rrq_sched_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the round-robin ready queue. It mirrors the ready ring and the
// current-process register, predicts each result beat and compares it.
// Depends on rrq_pkg only.

module rrq_sched_checker
  import rrq_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_tready,
  input  logic [IN_W-1:0]    in_tdata,
  input  logic [USER_W-1:0]  in_tuser,
  input  logic               out_tvalid,
  input  logic               out_tready,
  input  logic [OUT_W-1:0]   out_tdata,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [CFG_I_W-1:0] cfg_index,
  input  logic [CFG_D_W-1:0] cfg_data,
  output int unsigned        fail_count,
  output int unsigned        pending
);

  // Result beat, highest field first as on out_tdata
  typedef struct packed {
    logic [QCNT_W-1:0]  qcount;
    logic               cur_valid;
    logic [ID_BITS-1:0] cur_id;
    logic               prev_valid;
    logic [ID_BITS-1:0] prev_id;
    logic               switched;
    logic [1:0]         status;
  } sched_res_t;

  // Mirror of the scheduler state
  logic [ID_BITS-1:0] ring [QUEUE_DEPTH];
  logic [IDX_W-1:0]   ring_head;
  logic [IDX_W-1:0]   ring_tail;
  logic [CNT_W-1:0]   ring_count;
  logic [ID_BITS-1:0] run_id;
  logic               run_valid;
  logic [ID_BITS-1:0] idle_id;
  logic               idle_ok;

  sched_res_t  pending_results[$];
  int unsigned miscount = 0;
  int unsigned waiting  = 0;
  int unsigned result_no = 0;

  assign fail_count = miscount;
  assign pending    = waiting;

  function automatic logic [IDX_W-1:0] ring_slot(input int offset);
    return IDX_W'((int'(ring_head) + offset) % QUEUE_DEPTH);
  endfunction

  function automatic bit ring_push(input logic [ID_BITS-1:0] id);
    if (ring_count >= CNT_W'(QUEUE_DEPTH)) begin
      return 1'b0;
    end
    ring[ring_tail] = id;
    ring_tail = IDX_W'((int'(ring_tail) + 1) % QUEUE_DEPTH);
    ring_count = ring_count + 1'b1;
    return 1'b1;
  endfunction

  // Take out the first entry equal to id and close the gap behind it
  function automatic void ring_remove(input logic [ID_BITS-1:0] id);
    int  i;
    int  j;
    bit  found;
    found = 1'b0;
    for (i = 0; i < int'(ring_count) && !found; i++) begin
      if (ring[ring_slot(i)] == id) begin
        for (j = i; j + 1 < int'(ring_count); j++) begin
          ring[ring_slot(j)] = ring[ring_slot(j + 1)];
        end
        ring_tail = IDX_W'((int'(ring_tail) + QUEUE_DEPTH - 1) % QUEUE_DEPTH);
        ring_count = ring_count - 1'b1;
        found = 1'b1;
      end
    end
  endfunction

  // Apply one input beat to the mirror and return the result it causes
  function automatic sched_res_t apply_sched_op(input logic [1:0]         op,
                                                input logic [ID_BITS-1:0] pid,
                                                input logic               pid_ok,
                                                input logic [1:0]         cstat,
                                                input logic               irq);
    sched_res_t         r;
    logic [ID_BITS-1:0] nxt;
    bit                 have;
    r = '0;
    r.status     = ST_OK;
    r.prev_id    = run_valid ? run_id : '0;
    r.prev_valid = run_valid;
    case (op)
      OP_ADD: begin
        if (!ring_push(pid)) begin
          r.status = ST_FULL;
        end
      end
      OP_SET: begin
        run_valid = pid_ok;
        run_id    = pid_ok ? pid : '0;
      end
      OP_YIELD: begin
        if (irq) begin
          // interrupt context leaves everything as it was
          r.status = ST_NOSW;
        end else begin
          nxt  = '0;
          have = (ring_count != '0);
          if (have) begin
            nxt = ring[ring_head];
            ring_head = IDX_W'((int'(ring_head) + 1) % QUEUE_DEPTH);
            ring_count = ring_count - 1'b1;
          end
          if (run_valid && cstat == CS_RUNNING) begin
            void'(ring_push(run_id));
          end else if (run_valid && cstat == CS_EXITED) begin
            ring_remove(run_id);
          end
          if (!have && idle_ok) begin
            nxt  = idle_id;
            have = 1'b1;
          end
          if (have && (!run_valid || nxt != run_id)) begin
            run_id     = nxt;
            run_valid  = 1'b1;
            r.switched = 1'b1;
          end else begin
            r.status = ST_NOSW;
          end
        end
      end
      default: begin
        // unused code: no effect
      end
    endcase
    r.cur_id    = run_valid ? run_id : '0;
    r.cur_valid = run_valid;
    r.qcount    = QCNT_W'(ring_count);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] rrq result %0d: %s", $time, result_no, msg);
    miscount++;
  endtask

  task automatic check_field(input string what, input logic [ID_BITS-1:0] got,
                             input logic [ID_BITS-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", what, got, want));
    end
  endtask

  // Beats are sampled at the edge; output is matched before new input is queued
  always @(posedge clk) begin
    sched_res_t seen;
    sched_res_t want;
    if (!rst_n) begin
      ring_head  = '0;
      ring_tail  = '0;
      ring_count = '0;
      run_id     = '0;
      run_valid  = 1'b0;
      idle_id    = '0;
      idle_ok    = 1'b1;
      pending_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_IDLE_ID) begin
          idle_id = cfg_data;
        end else if (cfg_index == REG_IDLE_AVAIL) begin
          idle_ok = cfg_data[0];
        end
      end
      if (out_tvalid && out_tready) begin
        seen = sched_res_t'(out_tdata[$bits(sched_res_t)-1:0]);
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected beat 0x%0h", out_tdata));
        end else begin
          want = pending_results.pop_front();
          check_field("status", seen.status, want.status);
          check_field("switched", seen.switched, want.switched);
          check_field("previous_id", seen.prev_id, want.prev_id);
          check_field("previous_valid", seen.prev_valid, want.prev_valid);
          check_field("current_id", seen.cur_id, want.cur_id);
          check_field("current_valid", seen.cur_valid, want.cur_valid);
          check_field("queue_count", seen.qcount, want.qcount);
        end
        result_no++;
      end
      if (in_tvalid && in_tready) begin
        pending_results.push_back(apply_sched_op(in_tuser, in_tdata[15:0], in_tdata[16],
                                                 in_tdata[18:17], in_tdata[19]));
      end
    end
    waiting <= pending_results.size();
  end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the round-robin ready queue: clock, reset, stimulus, the
// result-side ready, a stall watchdog and the verdict. Uses rrq_pkg and rrq_sched_checker.

module tb_top
  import rrq_pkg::*;
();

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam logic [1:0] CS_OTHER    = 2'd2;
  localparam logic [1:0] CS_SPARE    = 2'd3;
  localparam int         HOLD_CYCLES = 300;
  localparam int         STALL_LIMIT = 4000;
  localparam int         TAIL_CYCLES = 20;
  localparam int         NUM_PHASES  = 7;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [IN_W-1:0]    in_tdata   = '0;
  logic [USER_W-1:0]  in_tuser   = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [OUT_W-1:0]   out_tdata;
  logic               cfg_valid  = 1'b0;
  logic               cfg_ready;
  logic [CFG_I_W-1:0] cfg_index  = '0;
  logic [CFG_D_W-1:0] cfg_data   = '0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned stall_cycles = 0;
  bit          gaps_on  = 1'b0;
  bit          hold_req = 1'b0;

  // Idle settings for the random phases, extremes included
  logic [15:0] phase_idle_id [NUM_PHASES] = '{16'h0000, 16'hFFFF, 16'h0005, 16'h8001,
                                              16'h0000, 16'hFFFF, 16'h0002};
  logic        phase_idle_ok [NUM_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  round_robin_ready_queue_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rrq_sched_checker sched_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // Result-side ready: random idling, or one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_tready <= !(gaps_on && $urandom_range(99) < 8);
      end
    end
  end

  // Watchdog: cycles in a row with no beat on any channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // One input beat; valid stays high afterwards unless a gap or a drain follows
  task automatic send_beat(input logic [1:0] op, input logic [15:0] pid, input logic pid_ok,
                           input logic [1:0] cstat, input logic irq);
    while (gaps_on && $urandom_range(99) < 8) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tuser  <= op;
    in_tdata  <= {4'b0000, irq, cstat, pid_ok, pid};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_random();
    int unsigned r;
    int unsigned c;
    logic [1:0]  op;
    logic [1:0]  cstat;
    logic [15:0] pid;
    r = $urandom_range(99);
    c = $urandom_range(9);
    if (r < 35) begin
      op = OP_ADD;
    end else if (r < 80) begin
      op = OP_YIELD;
    end else if (r < 96) begin
      op = OP_SET;
    end else begin
      op = OP_UNUSED;
    end
    // mostly a small pool of ids so that removals and equal picks happen
    pid = ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(7));
    if (c < 4) begin
      cstat = CS_RUNNING;
    end else if (c < 8) begin
      cstat = CS_EXITED;
    end else if (c == 8) begin
      cstat = CS_OTHER;
    end else begin
      cstat = CS_SPARE;
    end
    send_beat(op, pid, $urandom_range(9) != 0, cstat, $urandom_range(9) == 0);
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_I_W-1:0] idx, input logic [CFG_D_W-1:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_idle(input logic [15:0] id, input logic avail);
    drain();
    write_reg(REG_IDLE_ID, id);
    write_reg(REG_IDLE_AVAIL, {15'd0, avail});
  endtask

  initial begin
    int p;
    int k;
    int beats;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset configuration: idle id 0, idle available
    send_beat(OP_SET, 16'hFFFF, 1'b1, CS_RUNNING, 1'b0);
    send_beat(OP_SET, 16'h1234, 1'b0, CS_RUNNING, 1'b0);   // clear current
    send_beat(OP_YIELD, 16'h0000, 1'b0, CS_OTHER, 1'b0);   // empty queue, idle chosen
    send_beat(OP_YIELD, 16'hFFFF, 1'b1, CS_SPARE, 1'b0);   // idle equals current
    send_beat(OP_ADD, 16'hFFFF, 1'b0, CS_RUNNING, 1'b0);
    send_beat(OP_ADD, 16'h0000, 1'b1, CS_EXITED, 1'b1);
    send_beat(OP_ADD, 16'h5555, 1'b0, CS_OTHER, 1'b0);
    send_beat(OP_ADD, 16'hAAAA, 1'b1, CS_SPARE, 1'b1);
    send_beat(OP_UNUSED, 16'hFFFF, 1'b1, CS_SPARE, 1'b1);
    send_beat(OP_YIELD, 16'h0000, 1'b0, CS_RUNNING, 1'b1); // interrupt context
    send_beat(OP_YIELD, 16'h0000, 1'b0, CS_RUNNING, 1'b0); // re-queue current
    send_beat(OP_YIELD, 16'h0000, 1'b0, CS_EXITED, 1'b0);  // exited, not queued
    send_beat(OP_ADD, 16'h0007, 1'b0, CS_RUNNING, 1'b0);
    send_beat(OP_ADD, 16'h5555, 1'b0, CS_RUNNING, 1'b0);
    send_beat(OP_SET, 16'h5555, 1'b1, CS_RUNNING, 1'b0);
    send_beat(OP_YIELD, 16'h0000, 1'b0, CS_EXITED, 1'b0);  // removal, then same id picked

    // Idle process gone: empty queue picks nothing
    set_idle(16'hFFFF, 1'b0);
    for (k = 0; k < 4; k++) begin
      send_beat(OP_YIELD, 16'h0000, 1'b0, CS_OTHER, 1'b0);
    end
    send_beat(OP_YIELD, 16'h0000, 1'b0, CS_EXITED, 1'b0);
    set_idle(16'hFFFF, 1'b1);
    send_beat(OP_YIELD, 16'h0000, 1'b0, CS_EXITED, 1'b0);
    send_beat(OP_SET, 16'h0000, 1'b0, CS_RUNNING, 1'b0);
    send_beat(OP_YIELD, 16'h0000, 1'b0, CS_RUNNING, 1'b0);

    // Random phases; the first runs with no idling on either side
    for (p = 0; p < NUM_PHASES; p++) begin
      set_idle(phase_idle_id[p], phase_idle_ok[p]);
      gaps_on = (p != 0);
      beats = (p == 0) ? 60 : 40;
      if (p == 1) begin
        // overfill the ring so that adds are dropped
        for (k = 0; k < 262; k++) begin
          send_beat(OP_ADD, 16'($urandom_range(15)), $urandom_range(1) != 0,
                    2'($urandom_range(3)), $urandom_range(1) != 0);
        end
      end
      if (p == 2) begin
        hold_req = 1'b1;
      end
      for (k = 0; k < beats; k++) begin
        send_random();
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
